FILE: rtl/tplt_pkg.sv
package tplt_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int RUN_COUNT_BITS = 16;
  localparam int SUM_W          = SAMPLE_BITS + RUN_COUNT_BITS;
  localparam int LEN_W          = 8;
  localparam int CFG_W          = SAMPLE_BITS;
  localparam int CFG_IDX_W      = 2;
  localparam int TIME_W         = 32;
  localparam int RATIO_W        = 16;
  localparam int FRAC_BITS      = 12;
  localparam int RATIO_SHIFT    = RATIO_W - FRAC_BITS;

  localparam int DIV_W  = (SAMPLE_BITS > RUN_COUNT_BITS) ? SAMPLE_BITS : RUN_COUNT_BITS;
  localparam int LOW_W  = RATIO_W;
  localparam int STEP_W = $clog2(LOW_W + 1);

  localparam logic [RUN_COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_CAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_CAL  = 2'd3;

  localparam logic [1:0] PH_SEEK  = 2'd0;
  localparam logic [1:0] PH_BACK  = 2'd1;
  localparam logic [1:0] PH_READY = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  rem_init;
    logic [DIV_W-1:0]  divisor;
    logic [LOW_W-1:0]  low;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [LOW_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: rtl/tplt_div.sv
module tplt_div import tplt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  div_q, div_d;
  logic [LOW_W-1:0]  low_q, low_d;
  logic [LOW_W-1:0]  quot_q, quot_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // One quotient bit per cycle: restoring division with a narrow remainder.
  assign trial = {rem_q, low_q[LOW_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    rem_d  = rem_q;
    div_d  = div_q;
    low_d  = low_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.rem_init;
      div_d  = req_i.divisor;
      low_d  = req_i.low;
      quot_d = '0;
      cnt_d  = req_i.steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_d  = {low_q[LOW_W-2:0], 1'b0};
      quot_d = {quot_q[LOW_W-2:0], ge};
      cnt_d  = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: rtl/two_phase_stable_level_tracker.sv
// Channel  | Dir | Handshake              | Payload
// s_axis   | in  | tvalid/tready          | tuser: command; tdata: sample, timestamp
// m_axis   | out | tvalid/tready          | tdata: phase, ready_pulse, time_interval,
//          |     |                        |        distance_ratio, ratio_invalid
// cfg      | in  | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// An item may take a 10-step serial division for the run average, another 10 steps
// for a declared level, and 16 steps for the ratio while the throw is ready, all on
// one shared bit-serial divider.
// Reset clears the tracker state and loads the register defaults.
// The next item is accepted once the previous result is in the output register;
// a stalled output holds the block before it writes a new result.
module two_phase_stable_level_tracker import tplt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [47:0]            s_axis_tdata,   // sample, timestamp, zero pad
  input  logic                   s_axis_tuser,   // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // phase, ready_pulse, time_interval, distance_ratio, ratio_invalid, zero pad
  output logic [55:0]            m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_LVL  = 3'd2;
  localparam logic [2:0] S_RES  = 3'd3;
  localparam logic [2:0] S_RAT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  function automatic logic [SAMPLE_BITS-1:0] abs_diff(input logic [SAMPLE_BITS-1:0] a,
                                                      input logic [SAMPLE_BITS-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  logic [2:0]                state_q, state_d;
  logic [SAMPLE_BITS-1:0]    thr_q, front_cal_q, back_cal_q;
  logic [LEN_W-1:0]          len_q;
  logic [SAMPLE_BITS-1:0]    val_q, val_d;
  logic [TIME_W-1:0]         ts_q, ts_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [RUN_COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                      back_found_q, back_found_d;
  logic                      ready_q, ready_d;
  logic [SAMPLE_BITS-1:0]    back_lvl_q, back_lvl_d;
  logic [SAMPLE_BITS-1:0]    front_lvl_q, front_lvl_d;
  logic [TIME_W-1:0]         back_time_q, back_time_d;
  logic [TIME_W-1:0]         front_time_q, front_time_d;
  logic                      pulse_q, pulse_d;
  logic [RATIO_W-1:0]        ratio_q, ratio_d;
  logic                      inv_q, inv_d;
  logic                      m_valid_q, m_valid_d;
  logic [55:0]               m_data_q, m_data_d;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  logic                      in_fire;
  logic                      stable;
  logic [SUM_W-1:0]          new_sum;
  logic [RUN_COUNT_BITS-1:0] new_cnt;
  logic [SAMPLE_BITS-1:0]    span;
  logic [SAMPLE_BITS-1:0]    lvl_diff;
  logic [1:0]                phase;
  logic [TIME_W-1:0]         interval;

  tplt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign stable = (cnt_q == '0) ||
                  (abs_diff(div_rsp.quot[SAMPLE_BITS-1:0], val_q) <= thr_q);

  always_comb begin
    if (!stable) begin
      new_sum = SUM_W'(val_q);
      new_cnt = RUN_COUNT_BITS'(1);
    end else if (cnt_q != COUNT_MAX) begin
      new_sum = sum_q + SUM_W'(val_q);
      new_cnt = cnt_q + RUN_COUNT_BITS'(1);
    end else begin
      new_sum = sum_q;
      new_cnt = cnt_q;
    end
  end

  assign span     = abs_diff(back_cal_q, front_cal_q);
  assign lvl_diff = abs_diff(back_lvl_q, front_lvl_q);
  assign phase    = ready_q ? PH_READY : (back_found_q ? PH_BACK : PH_SEEK);
  assign interval = ready_q ? (front_time_q - back_time_q) : '0;

  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    ts_d         = ts_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    back_found_d = back_found_q;
    ready_d      = ready_q;
    back_lvl_d   = back_lvl_q;
    front_lvl_d  = front_lvl_q;
    back_time_d  = back_time_q;
    front_time_d = front_time_q;
    pulse_d      = pulse_q;
    ratio_d      = ratio_q;
    inv_d        = inv_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    m_data_d     = m_data_q;
    div_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d   = s_axis_tdata[SAMPLE_BITS-1:0];
          ts_d    = s_axis_tdata[SAMPLE_BITS +: TIME_W];
          pulse_d = 1'b0;
          if (s_axis_tuser) begin
            sum_d        = '0;
            cnt_d        = '0;
            back_found_d = 1'b0;
            ready_d      = 1'b0;
            back_lvl_d   = '0;
            front_lvl_d  = '0;
            back_time_d  = '0;
            front_time_d = '0;
            state_d      = S_RES;
          end else if (ready_q) begin
            state_d = S_RES;
          end else begin
            // The run sum stays below count << SAMPLE_BITS, so the average fits
            // in SAMPLE_BITS quotient bits.
            div_req.start    = (cnt_q != '0);
            div_req.rem_init = DIV_W'(sum_q >> SAMPLE_BITS);
            div_req.divisor  = DIV_W'(cnt_q);
            div_req.low      = LOW_W'(sum_q[SAMPLE_BITS-1:0]) << (LOW_W - SAMPLE_BITS);
            div_req.steps    = STEP_W'(SAMPLE_BITS);
            state_d          = S_AVG;
          end
        end
      end
      S_AVG: begin
        if (cnt_q == '0 || div_rsp.done) begin
          sum_d = new_sum;
          cnt_d = new_cnt;
          if (stable && new_cnt == RUN_COUNT_BITS'(len_q)) begin
            div_req.start    = 1'b1;
            div_req.rem_init = DIV_W'(new_sum >> SAMPLE_BITS);
            div_req.divisor  = DIV_W'(new_cnt);
            div_req.low      = LOW_W'(new_sum[SAMPLE_BITS-1:0]) << (LOW_W - SAMPLE_BITS);
            div_req.steps    = STEP_W'(SAMPLE_BITS);
            state_d          = S_LVL;
          end else begin
            state_d = S_RES;
          end
        end
      end
      S_LVL: begin
        if (div_rsp.done) begin
          if (!back_found_q) begin
            back_found_d = 1'b1;
            back_lvl_d   = div_rsp.quot[SAMPLE_BITS-1:0];
            back_time_d  = ts_q;
          end else begin
            ready_d      = 1'b1;
            front_lvl_d  = div_rsp.quot[SAMPLE_BITS-1:0];
            front_time_d = ts_q;
            pulse_d      = 1'b1;
          end
          state_d = S_RES;
        end
      end
      S_RES: begin
        ratio_d = '0;
        inv_d   = 1'b0;
        state_d = S_OUT;
        if (ready_q) begin
          if (span == '0) begin
            inv_d = 1'b1;
          end else if ((SAMPLE_BITS + RATIO_SHIFT)'(lvl_diff) >=
                       ((SAMPLE_BITS + RATIO_SHIFT)'(span) << RATIO_SHIFT)) begin
            ratio_d = '1;
          end else begin
            // The quotient stays below 2^16, so the top bits seed the remainder.
            div_req.start    = 1'b1;
            div_req.rem_init = DIV_W'(lvl_diff >> RATIO_SHIFT);
            div_req.divisor  = DIV_W'(span);
            div_req.low      = LOW_W'(lvl_diff[RATIO_SHIFT-1:0]) << (LOW_W - RATIO_SHIFT);
            div_req.steps    = STEP_W'(LOW_W);
            state_d          = S_RAT;
          end
        end
      end
      S_RAT: begin
        if (div_rsp.done) begin
          ratio_d = div_rsp.quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0, inv_q, ratio_q, interval, pulse_q, phase};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= SAMPLE_BITS'(8);
      len_q       <= LEN_W'(10);
      front_cal_q <= SAMPLE_BITS'(1023);
      back_cal_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESHOLD: thr_q       <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_RUN_LEN:   len_q       <= cfg_data_i[LEN_W-1:0];
        CFG_FRONT_CAL: front_cal_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_BACK_CAL:  back_cal_q  <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      sum_q        <= '0;
      cnt_q        <= '0;
      back_found_q <= 1'b0;
      ready_q      <= 1'b0;
      back_lvl_q   <= '0;
      front_lvl_q  <= '0;
      back_time_q  <= '0;
      front_time_q <= '0;
      pulse_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      sum_q        <= sum_d;
      cnt_q        <= cnt_d;
      back_found_q <= back_found_d;
      ready_q      <= ready_d;
      back_lvl_q   <= back_lvl_d;
      front_lvl_q  <= front_lvl_d;
      back_time_q  <= back_time_d;
      front_time_q <= front_time_d;
      pulse_q      <= pulse_d;
      m_valid_q    <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    ts_q     <= ts_d;
    ratio_q  <= ratio_d;
    inv_q    <= inv_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_ready_needs_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> back_found_q)
    else $error("throw ready without a back level");

  a_pulse_in_ready_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> (m_axis_tdata[1:0] == PH_READY))
    else $error("ready pulse outside the ready phase");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_AVG || state_q == S_LVL || state_q == S_RAT))
    else $error("divider finished while no division was pending");

  a_no_accept_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready)
    else $error("input accepted while an item is in progress");

endmodule

FILE: tb/sv/two_phase_stable_level_tracker_checker.sv
module two_phase_stable_level_tracker_checker
  import tplt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,   // sample, timestamp, zero pad
  input  logic                 s_axis_tuser,   // command
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // phase, ready_pulse, time_interval, distance_ratio, ratio_invalid, zero pad
  input  logic [55:0]          m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // The first member sits in the highest bits, so phase lands at bit 0.
  typedef struct packed {
    logic               ratio_invalid;
    logic [RATIO_W-1:0] distance_ratio;
    logic [TIME_W-1:0]  time_interval;
    logic               ready_pulse;
    logic [1:0]         phase;
  } throw_report_t;

  logic [CFG_W-1:0]          stable_thr;
  logic [LEN_W-1:0]          run_len;
  logic [CFG_W-1:0]          front_cal;
  logic [CFG_W-1:0]          back_cal;

  logic [SUM_W-1:0]          run_sum;
  logic [RUN_COUNT_BITS-1:0] run_count;
  bit                        back_found;
  bit                        throw_ready;
  logic [SAMPLE_BITS-1:0]    back_level;
  logic [SAMPLE_BITS-1:0]    front_level;
  logic [TIME_W-1:0]         back_time;
  logic [TIME_W-1:0]         front_time;

  throw_report_t             expected_reports[$];
  int                        mismatches = 0;

  function automatic logic [SAMPLE_BITS-1:0] level_gap(logic [SAMPLE_BITS-1:0] a,
                                                       logic [SAMPLE_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] run_mean();
    if (run_count == 0) begin
      return '0;
    end
    return SAMPLE_BITS'(run_sum / run_count);
  endfunction

  function automatic void clear_tracker();
    run_sum     = '0;
    run_count   = '0;
    back_found  = 1'b0;
    throw_ready = 1'b0;
    back_level  = '0;
    front_level = '0;
    back_time   = '0;
    front_time  = '0;
  endfunction

  function automatic throw_report_t track_sample(logic restart,
                                                 logic [SAMPLE_BITS-1:0] smp,
                                                 logic [TIME_W-1:0] ts);
    throw_report_t                    rep;
    logic [SAMPLE_BITS-1:0]           span;
    logic [SAMPLE_BITS+FRAC_BITS-1:0] quot;
    bit                               stable;
    rep = '0;
    if (restart) begin
      clear_tracker();
    end else if (!throw_ready) begin
      stable = (run_count == 0) || (level_gap(run_mean(), smp) <= stable_thr);
      if (!stable) begin
        run_sum   = SUM_W'(smp);
        run_count = 1;
      end else begin
        if (run_count != COUNT_MAX) begin
          run_sum   = run_sum + smp;
          run_count = run_count + 1'b1;
        end
        if (run_count == run_len) begin
          if (!back_found) begin
            back_found = 1'b1;
            back_level = run_mean();
            back_time  = ts;
          end else begin
            throw_ready     = 1'b1;
            front_level     = run_mean();
            front_time      = ts;
            rep.ready_pulse = 1'b1;
          end
        end
      end
    end
    if (throw_ready) begin
      rep.phase         = PH_READY;
      rep.time_interval = front_time - back_time;
      span              = level_gap(back_cal, front_cal);
      if (span == 0) begin
        rep.ratio_invalid = 1'b1;
      end else begin
        quot = {level_gap(back_level, front_level), {FRAC_BITS{1'b0}}} / span;
        rep.distance_ratio = (quot > {RATIO_W{1'b1}}) ? '1 : quot[RATIO_W-1:0];
      end
    end else begin
      rep.phase = back_found ? PH_BACK : PH_SEEK;
    end
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    throw_report_t want;
    throw_report_t got;
    if (!rst_ni) begin
      clear_tracker();
      stable_thr = 8;
      run_len    = 10;
      front_cal  = 1023;
      back_cal   = 0;
      expected_reports.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: stable_thr = cfg_data_i;
          CFG_RUN_LEN:   run_len    = cfg_data_i[LEN_W-1:0];
          CFG_FRONT_CAL: front_cal  = cfg_data_i;
          CFG_BACK_CAL:  back_cal   = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = track_sample(s_axis_tuser,
                            s_axis_tdata[SAMPLE_BITS-1:0],
                            s_axis_tdata[SAMPLE_BITS +: TIME_W]);
        expected_reports = {expected_reports, want};
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = throw_report_t'(m_axis_tdata[$bits(throw_report_t)-1:0]);
        if (expected_reports.size() == 0) begin
          $error("result arrived with no item outstanding: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
            mismatches++;
          end
          if (got.ready_pulse !== want.ready_pulse) begin
            $error("ready_pulse: expected %0d, got %0d", want.ready_pulse, got.ready_pulse);
            mismatches++;
          end
          if (got.time_interval !== want.time_interval) begin
            $error("time_interval: expected %0d, got %0d", want.time_interval,
                   got.time_interval);
            mismatches++;
          end
          if (got.distance_ratio !== want.distance_ratio) begin
            $error("distance_ratio: expected %0d, got %0d", want.distance_ratio,
                   got.distance_ratio);
            mismatches++;
          end
          if (got.ratio_invalid !== want.ratio_invalid) begin
            $error("ratio_invalid: expected %0d, got %0d", want.ratio_invalid,
                   got.ratio_invalid);
            mismatches++;
          end
        end
      end
      pending_o    <= expected_reports.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/sv/two_phase_stable_level_tracker_tb.sv
module two_phase_stable_level_tracker_tb;
  import tplt_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int SETTLE_CYCLES = 48;
  localparam int ROUND_ITEMS   = 150;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [47:0]          s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [55:0]          m_axis_tdata;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_THRESHOLD;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  int                   fail_count;
  int                   pending;
  int                   cycle_count = 0;
  int                   items_sent = 0;
  int                   rx_hold = 0;
  bit                   tx_idle = 1'b0;
  bit                   rx_idle = 1'b0;
  logic [TIME_W-1:0]    stamp = '0;

  two_phase_stable_level_tracker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  two_phase_stable_level_tracker_checker level_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[two_phase_stable_level_tracker] ERROR");
      $finish;
    end
  end

  // Each task below starts and ends on a rising edge.
  task automatic send_item(input logic restart, input logic [SAMPLE_BITS-1:0] smp,
                           input logic [TIME_W-1:0] ts);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= restart;
    s_axis_tdata  <= {6'b0, ts, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] len,
                               input logic [CFG_W-1:0] fcal, input logic [CFG_W-1:0] bcal);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RUN_LEN;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_FRONT_CAL;
    cfg_data_i <= fcal;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_BACK_CAL;
    cfg_data_i <= bcal;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] near(int level, int spread);
    int v;
    v = level + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_BITS'(v);
  endfunction

  function automatic logic [TIME_W-1:0] tick();
    if ($urandom_range(0, 99) == 0) begin
      stamp = $urandom;
    end else begin
      stamp = stamp + $urandom_range(1, 5000);
    end
    return stamp;
  endfunction

  initial begin
    int stall;
    @(posedge clk_i);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int thr;
    int len;
    int fcal;
    int bcal;
    int level;
    int run_items;
    int random_start;
    int round_start;
    logic [SAMPLE_BITS-1:0] smp;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale swing on both levels, with the timestamp wrapping.
    set_registers(0, 2, 1023, 0);
    send_item(1'b1, 10'h3FF, 32'hFFFF_FFFF);
    send_item(1'b0, 10'h000, 32'hFFFF_FFF0);
    send_item(1'b0, 10'h000, 32'h0000_0000);
    send_item(1'b0, 10'h3FF, 32'h0000_0007);
    send_item(1'b0, 10'h3FF, 32'hFFFF_FFFF);
    send_item(1'b0, 10'h00C, 32'h0000_0003);
    send_item(1'b1, 10'h000, 32'h0000_0000);

    // Zero span, then a span of one that saturates the ratio.
    wait_idle();
    set_registers(10, 2, 5, 5);
    send_item(1'b0, 10'd512, 32'd1);
    send_item(1'b0, 10'd512, 32'd2);
    send_item(1'b0, 10'd0, 32'd3);
    send_item(1'b0, 10'd0, 32'd1000);
    wait_idle();
    set_registers(10, 2, 0, 1);
    send_item(1'b0, 10'd77, 32'd5);
    send_item(1'b1, 10'd77, 32'd6);

    // A run length of one is met by a fresh run but never by a restarted one.
    wait_idle();
    set_registers(3, 1, 1023, 0);
    send_item(1'b0, 10'd100, 32'd10);
    send_item(1'b0, 10'd200, 32'd20);
    send_item(1'b0, 10'd201, 32'd30);
    send_item(1'b1, 10'd201, 32'd40);

    // Run length written as zero through the upper data bits, so no level is
    // ever declared.
    wait_idle();
    set_registers(1023, 10'h300, 1023, 0);
    send_item(1'b1, 10'd0, 32'd0);
    repeat (20) send_item(1'b0, 10'd500, 32'd1);
    repeat (20) send_item(1'b0, 10'd1023, 32'd2);
    wait_idle();
    set_registers(0, 2, 1023, 0);
    send_item(1'b0, 10'd500, 32'd3);
    send_item(1'b0, 10'd500, 32'd4);
    send_item(1'b1, 10'd0, 32'd5);

    stamp        = $urandom;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    random_start = items_sent;
    for (int round = 0; items_sent - random_start < RANDOM_ITEMS; round++) begin
      wait_idle();
      if (round == 0) begin
        thr = 0;
      end else if (round == 5) begin
        thr = 1023;
      end else begin
        thr = $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
      end
      len = (round == 1) ? 1 : (round == 3) ? 255 : $urandom_range(1, 12);
      case (round % 4)
        0: begin
          fcal = 1023;
          bcal = 0;
        end
        1: begin
          fcal = $urandom_range(0, 1023);
          bcal = fcal;
        end
        2: begin
          fcal = 0;
          bcal = 1023;
        end
        default: begin
          fcal = $urandom_range(0, 1023);
          bcal = $urandom_range(0, 1023);
        end
      endcase
      set_registers(CFG_W'(thr), CFG_W'(len), CFG_W'(fcal), CFG_W'(bcal));
      if (round == 2) begin
        rx_hold = 400;
      end
      round_start = items_sent;
      while (items_sent - round_start < ROUND_ITEMS) begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(1'b1, SAMPLE_BITS'($urandom), tick());
        end
        for (int side = 0; side < 2; side++) begin
          level     = $urandom_range(0, 1023);
          run_items = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len)
                                                  : len + $urandom_range(0, 3);
          repeat (run_items) begin
            if ($urandom_range(0, 24) == 0) begin
              smp = SAMPLE_BITS'($urandom);
            end else begin
              smp = near(level, thr / 2);
            end
            if ($urandom_range(0, 63) == 0) tx_idle = !tx_idle;
            if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
            send_item(1'b0, smp, tick());
          end
        end
        repeat ($urandom_range(0, 3)) send_item(1'b0, SAMPLE_BITS'($urandom), tick());
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("[two_phase_stable_level_tracker] OK");
    end else begin
      $display("[two_phase_stable_level_tracker] ERROR");
    end
    $finish;
  end

endmodule
